// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the console engine top level.
// Holds only macro definitions; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while out of reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/tccs_pkg.sv =====
// Shared types, codes and reset constants of the text console cursor scroller.
// No dependencies; every other RTL module imports this package.
package tccs_pkg;

    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int CFG_INDEX_W     = 3;
    localparam int CFG_DATA_W      = 10;

    localparam logic [1:0] CMD_PUT = 2'd0;
    localparam logic [1:0] CMD_SET = 2'd1;
    localparam logic [1:0] CMD_CLS = 2'd2;

    localparam logic [2:0] ACT_ROLL   = 3'd0;
    localparam logic [2:0] ACT_BAND   = 3'd1;
    localparam logic [2:0] ACT_GLYPH  = 3'd2;
    localparam logic [2:0] ACT_FLASH  = 3'd3;
    localparam logic [2:0] ACT_CLS    = 3'd4;
    localparam logic [2:0] ACT_REPORT = 3'd5;

    localparam logic [7:0] CHR_BEL = 8'h07;
    localparam logic [7:0] CHR_BS  = 8'h08;
    localparam logic [7:0] CHR_LF  = 8'h0A;
    localparam logic [7:0] CHR_CR  = 8'h0D;

    localparam logic [CFG_INDEX_W-1:0] REG_LCD_WIDTH    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LCD_HEIGHT   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_GLYPH_HEIGHT = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_GLYPH_WIDTH  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_COL      = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_ROW      = 3'd5;

    localparam logic [9:0] RST_LCD_WIDTH    = 10'd320;
    localparam logic [9:0] RST_LCD_HEIGHT   = 10'd128;
    localparam logic [4:0] RST_GLYPH_HEIGHT = 5'd8;
    localparam logic [3:0] RST_GLYPH_WIDTH  = 4'd6;
    localparam logic [7:0] RST_MAX_COL      = 8'd53;
    localparam logic [7:0] RST_MAX_ROW      = 8'd16;

    typedef struct packed {
        logic [9:0] lcd_width;
        logic [9:0] lcd_height;
        logic [4:0] glyph_height;
        logic [3:0] glyph_width;
        logic [7:0] max_col;
        logic [7:0] max_row;
    } cfg_t;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_FLASH,
        OP_GLYPH,
        OP_SET,
        OP_BACK,
        OP_NEWLINE,
        OP_CR,
        OP_CLS
    } op_kind_t;

    typedef struct packed {
        op_kind_t   kind;
        logic [7:0] code;
        logic [7:0] row;
        logic [7:0] col;
    } op_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [15:0] pos_x;
        logic [10:0] pos_y;
        logic [9:0]  area_width;
        logic [4:0]  area_height;
        logic [7:0]  glyph_code;
        logic [9:0]  roll_value;
        logic [7:0]  report_row;
        logic [7:0]  report_col;
        logic        last;
    } res_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCROLL,
        ST_PROD,
        ST_PLACE,
        ST_GLYPH,
        ST_FLASH,
        ST_CLS,
        ST_CLS_ROLL,
        ST_REPORT
    } back_state_t;

endpackage

// ===== rtl/core/text_console_cursor_scroller_unit.sv =====
// Top level of the text console cursor scroller: configuration registers and the
// front end, queue and executor. Depends on tccs_pkg and assert_macros.svh.
//
// Commands (put character, set cursor, clear screen) come in on the cmd channel and
// each produces one to four display actions on the res channel, the final one a
// cursor report with last set. A command is classified on entry and queued, so new
// commands are taken while earlier ones are still being carried out. The executor
// issues at most one action per cycle, held by res stalls. A bell, clear screen or
// unwrapped printable gives its actions before the report; a cursor move (set cursor,
// backspace, newline, carriage return, wrapping character) adds roll and band if it
// scrolls and a glyph after a wrap. Configuration is written through cfg_we, cfg_index
// and cfg_data; the user must write it only while idle; the block does not enforce it.
`include "assert_macros.svh"

module text_console_cursor_scroller_unit
    import tccs_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   cmd_valid,
    output logic                   cmd_ready,
    input  logic [1:0]             cmd,
    input  logic [7:0]             char_code,
    input  logic [7:0]             target_row,
    input  logic [7:0]             target_col,
    output logic                   res_valid,
    input  logic                   res_ready,
    output logic [2:0]             action,
    output logic [15:0]            pos_x,
    output logic [10:0]            pos_y,
    output logic [9:0]             area_width,
    output logic [4:0]             area_height,
    output logic [7:0]             glyph_code,
    output logic [9:0]             roll_value,
    output logic [7:0]             report_row,
    output logic [7:0]             report_col,
    output logic                   last
);

    cfg_t          cfg_reg;
    cfg_t          cfg_next;
    queue_status_t q_status;
    logic          push;
    op_t           push_op;
    logic          q_pop;
    op_t           q_op;
    res_t          res;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LCD_WIDTH:    cfg_next.lcd_width    = cfg_data[9:0];
                REG_LCD_HEIGHT:   cfg_next.lcd_height   = {cfg_data[9:1], 1'b0};
                REG_GLYPH_HEIGHT: cfg_next.glyph_height = cfg_data[4:0];
                REG_GLYPH_WIDTH:  cfg_next.glyph_width  = cfg_data[3:0];
                REG_MAX_COL:      cfg_next.max_col      = cfg_data[7:0];
                REG_MAX_ROW:      cfg_next.max_row      = cfg_data[7:0];
                default:          cfg_next              = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lcd_width    <= RST_LCD_WIDTH;
            cfg_reg.lcd_height   <= RST_LCD_HEIGHT;
            cfg_reg.glyph_height <= RST_GLYPH_HEIGHT;
            cfg_reg.glyph_width  <= RST_GLYPH_WIDTH;
            cfg_reg.max_col      <= RST_MAX_COL;
            cfg_reg.max_row      <= RST_MAX_ROW;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    tccs_front u_front (
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd),
        .char_code  (char_code),
        .target_row (target_row),
        .target_col (target_col),
        .q_status   (q_status),
        .push       (push),
        .push_op    (push_op)
    );

    tccs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (q_pop),
        .head_op (q_op),
        .status  (q_status)
    );

    tccs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_op      (q_op),
        .q_status  (q_status),
        .q_pop     (q_pop),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign action      = res.action;
    assign pos_x       = res.pos_x;
    assign pos_y       = res.pos_y;
    assign area_width  = res.area_width;
    assign area_height = res.area_height;
    assign glyph_code  = res.glyph_code;
    assign roll_value  = res.roll_value;
    assign report_row  = res.report_row;
    assign report_col  = res.report_col;
    assign last        = res.last;

    `ASSERT_IMPLIES(a_last_only_on_report, clk, rst_n, res_valid,
        last == (action == ACT_REPORT), "last does not match cursor report")
    `ASSERT_NEXT(a_accept_fills_queue, clk, rst_n, cmd_valid && cmd_ready,
        !q_status.empty, "accepted command missing from queue")
    `ASSERT_IMPLIES(a_height_even, clk, rst_n, 1'b1,
        cfg_reg.lcd_height[0] == 1'b0, "display height register is odd")

endmodule

// ===== rtl/core/tccs_front.sv =====
// Command front end: input handshake and classification into queue operations.
// Depends on tccs_pkg.
module tccs_front
    import tccs_pkg::*;
(
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  logic [1:0]    cmd,
    input  logic [7:0]    char_code,
    input  logic [7:0]    target_row,
    input  logic [7:0]    target_col,
    input  queue_status_t q_status,
    output logic          push,
    output op_t           push_op
);

    assign cmd_ready = !q_status.full;
    assign push      = cmd_valid && !q_status.full;

    always_comb
    begin
        push_op      = '0;
        push_op.code = char_code;
        push_op.row  = target_row;
        push_op.col  = target_col;
        unique case (cmd)
            CMD_PUT:
            begin
                unique case (char_code)
                    CHR_BEL: push_op.kind = OP_FLASH;
                    CHR_BS:  push_op.kind = OP_BACK;
                    CHR_LF:  push_op.kind = OP_NEWLINE;
                    CHR_CR:  push_op.kind = OP_CR;
                    default: push_op.kind = OP_GLYPH;
                endcase
            end
            CMD_SET: push_op.kind = OP_SET;
            CMD_CLS: push_op.kind = OP_CLS;
            default: push_op.kind = OP_NOP;
        endcase
    end

endmodule

// ===== rtl/core/tccs_queue.sv =====
// Short operation queue between the command front end and the executor.
// Depends on tccs_pkg for the operation type.
module tccs_queue
    import tccs_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  op_t           push_op,
    input  logic          pop,
    output op_t           head_op,
    output queue_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    op_t              entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign status.full  = (count_reg == FULL_CNT);
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_op      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

// ===== rtl/core/tccs_back.sv =====
// Executor: cursor, roll and pixel state, the action sequencer and the result register.
// Depends on tccs_pkg.
module tccs_back
    import tccs_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  cfg_t          cfg,
    input  op_t           q_op,
    input  queue_status_t q_status,
    output logic          q_pop,
    output logic          res_valid,
    input  logic          res_ready,
    output res_t          res
);

    back_state_t state_reg;
    back_state_t state_next;
    op_kind_t    kind_reg;
    op_kind_t    kind_next;
    logic [7:0]  code_reg;
    logic [7:0]  code_next;
    logic [7:0]  mv_row_reg;
    logic [7:0]  mv_row_next;
    logic [7:0]  mv_col_reg;
    logic [7:0]  mv_col_next;
    logic [15:0] x_prod_reg;
    logic [15:0] x_prod_next;
    logic [15:0] y_prod_reg;
    logic [15:0] y_prod_next;
    logic        band_reg;
    logic        band_next;
    logic [7:0]  row_reg;
    logic [7:0]  row_next;
    logic [7:0]  col_reg;
    logic [7:0]  col_next;
    logic [9:0]  roll_reg;
    logic [9:0]  roll_next;
    logic [15:0] px_x_reg;
    logic [15:0] px_x_next;
    logic [10:0] px_y_reg;
    logic [10:0] px_y_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    res_t        out_reg;
    res_t        out_next;

    logic        slot_free;
    logic        emit;
    res_t        emit_res;
    logic        can_take;
    back_state_t disp_state;
    logic [7:0]  disp_row;
    logic [7:0]  disp_col;
    logic        wrap_x;
    logic        row_low;
    logic        row_out;
    logic [11:0] roll_dn;
    logic [11:0] roll_up;
    logic [9:0]  new_roll;
    logic [15:0] col_m1;
    logic [15:0] row_m1;
    logic [15:0] place_x;
    logic [15:0] y_sum;
    logic [15:0] place_y;
    logic [15:0] adv_x;

    assign res_valid = out_valid_reg;
    assign res       = out_reg;
    assign slot_free = !out_valid_reg || res_ready;

    assign wrap_x = (cfg.lcd_width != '0)
                 && (px_x_reg == 16'(cfg.lcd_width - 10'd1));

    always_comb
    begin
        disp_row   = row_reg;
        disp_col   = col_reg;
        disp_state = ST_SCROLL;
        unique case (q_op.kind)
            OP_NOP:   disp_state = ST_REPORT;
            OP_FLASH: disp_state = ST_FLASH;
            OP_CLS:   disp_state = ST_CLS;
            OP_SET:
            begin
                disp_row = q_op.row;
                disp_col = q_op.col;
            end
            OP_BACK:
            begin
                if (col_reg > 8'd1)
                begin
                    disp_col = col_reg - 8'd1;
                end
                else
                begin
                    disp_row = row_reg - 8'd1;
                    disp_col = cfg.max_col;
                end
            end
            OP_NEWLINE:
            begin
                disp_row = row_reg + 8'd1;
                disp_col = 8'd1;
            end
            OP_CR: disp_col = 8'd1;
            OP_GLYPH:
            begin
                if (wrap_x)
                begin
                    disp_row = row_reg + 8'd1;
                    disp_col = 8'd1;
                end
                else
                begin
                    disp_state = ST_GLYPH;
                end
            end
        endcase
    end

    // The roll moves by one glyph height and wraps around the display height.
    always_comb
    begin
        row_low = (mv_row_reg == '0);
        row_out = row_low || (mv_row_reg > cfg.max_row);
        roll_dn = {2'b00, roll_reg} - {7'd0, cfg.glyph_height};
        if (roll_dn[11])
        begin
            roll_dn = roll_dn + {2'b00, cfg.lcd_height};
        end
        roll_up = {2'b00, roll_reg} + {7'd0, cfg.glyph_height};
        if (roll_up >= {2'b00, cfg.lcd_height})
        begin
            roll_up = roll_up - {2'b00, cfg.lcd_height};
        end
        new_roll = row_low ? roll_dn[9:0] : roll_up[9:0];
    end

    always_comb
    begin
        col_m1  = 16'(mv_col_reg) - 16'd1;
        row_m1  = 16'(mv_row_reg) - 16'd1;
        place_x = x_prod_reg;
        if (place_x == 16'(cfg.lcd_width))
        begin
            place_x = place_x - 16'd1;
        end
        y_sum   = y_prod_reg + 16'(roll_reg);
        place_y = y_sum;
        if (y_sum >= 16'(cfg.lcd_height))
        begin
            place_y = y_sum - 16'(cfg.lcd_height);
        end
        adv_x = px_x_reg + 16'(cfg.glyph_width);
        if (adv_x == 16'(cfg.lcd_width))
        begin
            adv_x = adv_x - 16'd1;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        kind_next   = kind_reg;
        code_next   = code_reg;
        mv_row_next = mv_row_reg;
        mv_col_next = mv_col_reg;
        x_prod_next = x_prod_reg;
        y_prod_next = y_prod_reg;
        band_next   = band_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        roll_next   = roll_reg;
        px_x_next   = px_x_reg;
        px_y_next   = px_y_reg;
        emit        = 1'b0;
        emit_res    = '0;
        can_take    = 1'b0;

        unique case (state_reg)
            ST_IDLE: can_take = 1'b1;
            ST_SCROLL:
            begin
                if (row_out)
                begin
                    emit                = 1'b1;
                    emit_res.action     = ACT_ROLL;
                    emit_res.roll_value = new_roll;
                    if (slot_free)
                    begin
                        roll_next   = new_roll;
                        mv_row_next = row_low ? 8'd1 : cfg.max_row;
                        band_next   = 1'b1;
                        state_next  = ST_PROD;
                    end
                end
                else
                begin
                    band_next  = 1'b0;
                    state_next = ST_PROD;
                end
            end
            ST_PROD:
            begin
                x_prod_next = col_m1 * 16'(cfg.glyph_width);
                y_prod_next = row_m1 * 16'(cfg.glyph_height);
                state_next  = ST_PLACE;
            end
            ST_PLACE:
            begin
                emit                 = band_reg;
                emit_res.action      = ACT_BAND;
                emit_res.pos_x       = place_x;
                emit_res.pos_y       = place_y[10:0];
                emit_res.area_width  = cfg.lcd_width;
                emit_res.area_height = cfg.glyph_height;
                if (!band_reg || slot_free)
                begin
                    row_next   = mv_row_reg;
                    col_next   = mv_col_reg;
                    px_x_next  = place_x;
                    px_y_next  = place_y[10:0];
                    state_next = (kind_reg == OP_GLYPH) ? ST_GLYPH : ST_REPORT;
                end
            end
            ST_GLYPH:
            begin
                emit                 = 1'b1;
                emit_res.action      = ACT_GLYPH;
                emit_res.pos_x       = px_x_reg;
                emit_res.pos_y       = px_y_reg;
                emit_res.area_width  = {6'd0, cfg.glyph_width};
                emit_res.area_height = cfg.glyph_height;
                emit_res.glyph_code  = code_reg;
                if (slot_free)
                begin
                    px_x_next  = adv_x;
                    col_next   = col_reg + 8'd1;
                    state_next = ST_REPORT;
                end
            end
            ST_FLASH:
            begin
                emit            = 1'b1;
                emit_res.action = ACT_FLASH;
                if (slot_free)
                begin
                    state_next = ST_REPORT;
                end
            end
            ST_CLS:
            begin
                emit            = 1'b1;
                emit_res.action = ACT_CLS;
                if (slot_free)
                begin
                    row_next   = 8'd1;
                    col_next   = 8'd1;
                    roll_next  = '0;
                    px_x_next  = '0;
                    px_y_next  = '0;
                    state_next = ST_CLS_ROLL;
                end
            end
            ST_CLS_ROLL:
            begin
                emit            = 1'b1;
                emit_res.action = ACT_ROLL;
                if (slot_free)
                begin
                    state_next = ST_REPORT;
                end
            end
            ST_REPORT:
            begin
                emit                = 1'b1;
                emit_res.action     = ACT_REPORT;
                emit_res.pos_x      = px_x_reg;
                emit_res.pos_y      = px_y_reg;
                emit_res.report_row = row_reg;
                emit_res.report_col = col_reg;
                emit_res.last       = 1'b1;
                if (slot_free)
                begin
                    can_take   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        q_pop = can_take && !q_status.empty;
        if (q_pop)
        begin
            state_next  = disp_state;
            kind_next   = q_op.kind;
            code_next   = q_op.code;
            mv_row_next = disp_row;
            mv_col_next = disp_col;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (emit && slot_free)
        begin
            out_valid_next = 1'b1;
            out_next       = emit_res;
        end
        else if (res_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            band_reg      <= 1'b0;
            row_reg       <= 8'd1;
            col_reg       <= 8'd1;
            roll_reg      <= '0;
            px_x_reg      <= '0;
            px_y_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            band_reg      <= band_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            roll_reg      <= roll_next;
            px_x_reg      <= px_x_next;
            px_y_reg      <= px_y_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        code_reg   <= code_next;
        mv_row_reg <= mv_row_next;
        mv_col_reg <= mv_col_next;
        x_prod_reg <= x_prod_next;
        y_prod_reg <= y_prod_next;
        out_reg    <= out_next;
    end

endmodule

// ===== tb/console_action_checker.sv =====
// Predicts the display actions of the text console cursor scroller and compares every
// result beat against them, counting mismatches for the testbench top.
// Depends on tccs_pkg for the action, command, character and register codes.
module console_action_checker
    import tccs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   cmd_valid,
    input  logic                   cmd_ready,
    input  logic [1:0]             cmd,
    input  logic [7:0]             char_code,
    input  logic [7:0]             target_row,
    input  logic [7:0]             target_col,
    input  logic                   res_valid,
    input  logic                   res_ready,
    input  logic [2:0]             action,
    input  logic [15:0]            pos_x,
    input  logic [10:0]            pos_y,
    input  logic [9:0]             area_width,
    input  logic [4:0]             area_height,
    input  logic [7:0]             glyph_code,
    input  logic [9:0]             roll_value,
    input  logic [7:0]             report_row,
    input  logic [7:0]             report_col,
    input  logic                   last,
    output int                     mismatches,
    output int                     backlog
);
    timeunit 1ns;
    timeprecision 1ps;

    cfg_t        disp;
    logic [7:0]  cur_row;
    logic [7:0]  cur_col;
    logic [9:0]  roll;
    logic [15:0] px_x;
    logic [10:0] px_y;
    res_t        actions_due[$];
    res_t        seen;
    res_t        wanted;

    function automatic res_t plain_action(input logic [2:0] kind);
        res_t a;
        a = '0;
        a.action = kind;
        return a;
    endfunction

    function automatic string describe(input res_t a);
        return $sformatf("act=%0d x=%0d y=%0d w=%0d h=%0d code=%0d roll=%0d row=%0d col=%0d last=%0d",
                         a.action, a.pos_x, a.pos_y, a.area_width, a.area_height,
                         a.glyph_code, a.roll_value, a.report_row, a.report_col, a.last);
    endfunction

    // A row outside 1..max_row scrolls by one glyph height and clears the exposed band.
    task automatic move_cursor_to(input int unsigned row_in, input int unsigned col_in);
        int unsigned row;
        int unsigned col;
        int unsigned x;
        int unsigned y;
        int          r;
        logic        scrolled;
        res_t        a;
        row = row_in & 32'hFF;
        col = col_in & 32'hFF;
        scrolled = 1'b0;
        if (row < 1 || row > disp.max_row)
        begin
            r = int'(roll);
            if (row < 1)
            begin
                row = 1;
                r = r - int'(disp.glyph_height);
                if (r < 0) r = r + int'(disp.lcd_height);
            end
            else
            begin
                row = disp.max_row;
                r = r + int'(disp.glyph_height);
                if (r >= int'(disp.lcd_height)) r = r - int'(disp.lcd_height);
            end
            roll = r[9:0];
            a = plain_action(ACT_ROLL);
            a.roll_value = roll;
            actions_due.push_back(a);
            scrolled = 1'b1;
        end
        cur_row = row[7:0];
        cur_col = col[7:0];
        x = ((col - 1) * disp.glyph_width) & 32'hFFFF;
        if (x == disp.lcd_width) x = x - 1;
        y = ((row - 1) * disp.glyph_height + roll) & 32'hFFFF;
        if (y >= disp.lcd_height) y = y - disp.lcd_height;
        px_x = x[15:0];
        px_y = y[10:0];
        if (scrolled)
        begin
            a = plain_action(ACT_BAND);
            a.pos_x = px_x;
            a.pos_y = px_y;
            a.area_width = disp.lcd_width;
            a.area_height = disp.glyph_height;
            actions_due.push_back(a);
        end
    endtask

    task automatic put_char(input logic [7:0] ch);
        res_t a;
        case (ch)
            CHR_BEL: actions_due.push_back(plain_action(ACT_FLASH));
            CHR_BS:
                if (cur_col > 8'd1) move_cursor_to(cur_row, cur_col - 8'd1);
                else move_cursor_to(cur_row - 8'd1, disp.max_col);
            CHR_LF: move_cursor_to(cur_row + 8'd1, 1);
            CHR_CR: move_cursor_to(cur_row, 1);
            default:
            begin
                if (int'(px_x) == int'(disp.lcd_width) - 1) move_cursor_to(cur_row + 8'd1, 1);
                a = plain_action(ACT_GLYPH);
                a.pos_x = px_x;
                a.pos_y = px_y;
                a.area_width = 10'(disp.glyph_width);
                a.area_height = disp.glyph_height;
                a.glyph_code = ch;
                actions_due.push_back(a);
                px_x = px_x + 16'(disp.glyph_width);
                if (px_x == 16'(disp.lcd_width)) px_x = px_x - 16'd1;
                cur_col = cur_col + 8'd1;
            end
        endcase
    endtask

    task automatic predict_screen_actions(input logic [1:0] op, input logic [7:0] ch,
                                          input logic [7:0] row, input logic [7:0] col);
        res_t a;
        case (op)
            CMD_PUT: put_char(ch);
            CMD_SET: move_cursor_to(row, col);
            CMD_CLS:
            begin
                actions_due.push_back(plain_action(ACT_CLS));
                cur_row = 8'd1;
                cur_col = 8'd1;
                roll = '0;
                px_x = '0;
                px_y = '0;
                actions_due.push_back(plain_action(ACT_ROLL));
            end
            default: ;
        endcase
        a = plain_action(ACT_REPORT);
        a.pos_x = px_x;
        a.pos_y = px_y;
        a.report_row = cur_row;
        a.report_col = cur_col;
        a.last = 1'b1;
        actions_due.push_back(a);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            disp = '{lcd_width: RST_LCD_WIDTH, lcd_height: RST_LCD_HEIGHT,
                     glyph_height: RST_GLYPH_HEIGHT, glyph_width: RST_GLYPH_WIDTH,
                     max_col: RST_MAX_COL, max_row: RST_MAX_ROW};
            cur_row = 8'd1;
            cur_col = 8'd1;
            roll = '0;
            px_x = '0;
            px_y = '0;
            actions_due.delete();
            mismatches = 0;
            backlog = 0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                seen = '{action: action, pos_x: pos_x, pos_y: pos_y, area_width: area_width,
                         area_height: area_height, glyph_code: glyph_code,
                         roll_value: roll_value, report_row: report_row,
                         report_col: report_col, last: last};
                if (actions_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected result beat: %s", describe(seen));
                end
                else
                begin
                    wanted = actions_due.pop_front();
                    if (seen !== wanted)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Result mismatch: expected %s, got %s",
                                     describe(wanted), describe(seen));
                    end
                end
            end
            if (cmd_valid && cmd_ready)
                predict_screen_actions(cmd, char_code, target_row, target_col);
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_LCD_WIDTH:    disp.lcd_width = cfg_data[9:0];
                    REG_LCD_HEIGHT:   disp.lcd_height = {cfg_data[9:1], 1'b0};
                    REG_GLYPH_HEIGHT: disp.glyph_height = cfg_data[4:0];
                    REG_GLYPH_WIDTH:  disp.glyph_width = cfg_data[3:0];
                    REG_MAX_COL:      disp.max_col = cfg_data[7:0];
                    REG_MAX_ROW:      disp.max_row = cfg_data[7:0];
                    default: ;
                endcase
            end
            backlog = actions_due.size();
        end
    end

endmodule

// ===== tb/testbench.sv =====
// Top of the console scroller testbench: clock, reset, command and configuration
// stimulus, result back-pressure and the verdict. Depends on tccs_pkg, the
// text_console_cursor_scroller_unit RTL and console_action_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import tccs_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int RANDOM_PER_PHASE = 30;
    localparam int HOLD_AT          = 60;
    localparam int HOLD_CYCLES      = 80;
    localparam int QUIET_FROM       = 205;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int SETTLE_CYCLES    = 8;

    logic                   clk;
    logic                   rst_n      = 1'b0;
    logic                   cfg_we     = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index  = REG_LCD_WIDTH;
    logic [CFG_DATA_W-1:0]  cfg_data   = '0;
    logic                   cmd_valid  = 1'b0;
    logic                   cmd_ready;
    logic [1:0]             cmd        = CMD_PUT;
    logic [7:0]             char_code  = '0;
    logic [7:0]             target_row = '0;
    logic [7:0]             target_col = 8'd1;
    logic                   res_valid;
    logic                   res_ready  = 1'b0;
    logic [2:0]             action;
    logic [15:0]            pos_x;
    logic [10:0]            pos_y;
    logic [9:0]             area_width;
    logic [4:0]             area_height;
    logic [7:0]             glyph_code;
    logic [9:0]             roll_value;
    logic [7:0]             report_row;
    logic [7:0]             report_col;
    logic                   last;

    int         mismatches;
    int         backlog;
    int         cmds_taken   = 0;
    int         reports_seen = 0;
    int         stuck_cycles = 0;
    int         items_sent   = 0;
    logic [7:0] rows_now     = RST_MAX_ROW;
    logic [7:0] cols_now     = RST_MAX_COL;

    text_console_cursor_scroller_unit uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd), .char_code(char_code),
        .target_row(target_row), .target_col(target_col),
        .res_valid(res_valid), .res_ready(res_ready), .action(action),
        .pos_x(pos_x), .pos_y(pos_y), .area_width(area_width), .area_height(area_height),
        .glyph_code(glyph_code), .roll_value(roll_value),
        .report_row(report_row), .report_col(report_col), .last(last)
    );

    console_action_checker action_check (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd), .char_code(char_code),
        .target_row(target_row), .target_col(target_col),
        .res_valid(res_valid), .res_ready(res_ready), .action(action),
        .pos_x(pos_x), .pos_y(pos_y), .area_width(area_width), .area_height(area_height),
        .glyph_code(glyph_code), .roll_value(roll_value),
        .report_row(report_row), .report_col(report_col), .last(last),
        .mismatches(mismatches), .backlog(backlog)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cmd_valid && cmd_ready) cmds_taken <= cmds_taken + 1;
            if (res_valid && res_ready && last) reports_seen <= reports_seen + 1;
            if ((cmd_valid && cmd_ready) || (res_valid && res_ready))
                stuck_cycles <= 0;
            else
                stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles == WATCHDOG_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    function automatic logic sender_may_idle();
        return !(cmds_taken >= HOLD_AT - 5 && cmds_taken < HOLD_AT + 30)
            && cmds_taken < QUIET_FROM && (cmds_taken / 16) % 4 != 3;
    endfunction

    function automatic logic receiver_may_idle();
        return cmds_taken < QUIET_FROM && (cmds_taken / 16) % 4 != 1;
    endfunction

    // The receiver stalls in short bursts, and once for a long stretch so the block backs up.
    initial
    begin
        logic held;
        held = 1'b0;
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (!held && cmds_taken >= HOLD_AT)
            begin
                held = 1'b1;
                res_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (receiver_may_idle() && $urandom_range(0, 5) == 0)
            begin
                res_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
            res_ready <= 1'b1;
            @(posedge clk);
        end
    end

    task automatic send_cmd(input logic [1:0] op, input logic [7:0] ch,
                            input logic [7:0] row, input logic [7:0] col);
        if (sender_may_idle() && $urandom_range(0, 3) == 0)
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd <= op;
        char_code <= ch;
        target_row <= row;
        target_col <= col;
        items_sent++;
        @(posedge clk);
        while (!cmd_ready) @(posedge clk);
    endtask

    task automatic drain();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (reports_seen != cmds_taken) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_display(input logic [9:0] width, input logic [9:0] height,
                                   input logic [4:0] cell_h, input logic [3:0] cell_w,
                                   input logic [7:0] cols, input logic [7:0] rows);
        logic [CFG_INDEX_W-1:0] idx [6];
        logic [CFG_DATA_W-1:0]  val [6];
        idx = '{REG_LCD_WIDTH, REG_LCD_HEIGHT, REG_GLYPH_HEIGHT,
                REG_GLYPH_WIDTH, REG_MAX_COL, REG_MAX_ROW};
        val = '{width, height, 10'(cell_h), 10'(cell_w), 10'(cols), 10'(rows)};
        drain();
        for (int i = 0; i < 6; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= val[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
        rows_now = rows;
        cols_now = cols;
    endtask

    // Widths often land on a multiple of the cell width, or one past it, to hit line wrap.
    task automatic program_random_display();
        logic [3:0] cell_w;
        logic [9:0] width;
        logic [7:0] cols;
        logic [7:0] rows;
        cell_w = 4'($urandom_range(1, 15));
        if ($urandom_range(0, 1))
            width = 10'($urandom_range(1, 20) * cell_w + $urandom_range(0, 1));
        else
            width = 10'($urandom_range(1, 1023));
        cols = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255)) : 8'($urandom_range(1, 40));
        rows = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255)) : 8'($urandom_range(1, 12));
        program_display(width, 10'($urandom_range(2, 1022)), 5'($urandom_range(1, 31)),
                        cell_w, cols, rows);
    endtask

    task automatic send_random();
        int         pick;
        int         run;
        logic [7:0] row;
        logic [7:0] col;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 3) == 0)
            row = 8'($urandom);
        else
            row = 8'($urandom_range(0, (rows_now == 8'hFF) ? 255 : rows_now + 1));
        if ($urandom_range(0, 3) == 0)
            col = 8'($urandom_range(1, 255));
        else
            col = 8'($urandom_range(1, cols_now));
        if (pick < 40)
            send_cmd(CMD_PUT, 8'($urandom), 8'($urandom), col);
        else if (pick < 47)
            send_cmd(CMD_PUT, CHR_BEL, row, col);
        else if (pick < 57)
            send_cmd(CMD_PUT, CHR_BS, row, col);
        else if (pick < 66)
            send_cmd(CMD_PUT, CHR_LF, row, col);
        else if (pick < 71)
            send_cmd(CMD_PUT, CHR_CR, row, col);
        else if (pick < 85)
            send_cmd(CMD_SET, 8'($urandom), row, col);
        else if (pick < 89)
            send_cmd(CMD_CLS, 8'($urandom), row, col);
        else
        begin
            run = $urandom_range(5, 20);
            repeat (run) send_cmd(CMD_PUT, 8'($urandom_range(32, 255)), row, col);
        end
    endtask

    task automatic run_random(input int count);
        int stop_at;
        stop_at = items_sent + count;
        while (items_sent < stop_at) send_random();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_cmd(CMD_PUT, 8'h00, 8'd0, 8'd1);
        send_cmd(CMD_PUT, 8'hFF, 8'hFF, 8'hFF);
        send_cmd(CMD_PUT, CHR_BEL, 8'd0, 8'd1);
        send_cmd(CMD_PUT, CHR_CR, 8'd0, 8'd1);
        send_cmd(CMD_PUT, CHR_BS, 8'd0, 8'd1);
        send_cmd(CMD_PUT, CHR_BS, 8'd0, 8'd1);
        send_cmd(CMD_PUT, CHR_LF, 8'd0, 8'd1);
        send_cmd(CMD_SET, 8'h00, 8'd0, 8'd1);
        send_cmd(CMD_SET, 8'h00, 8'd255, 8'd255);
        send_cmd(CMD_SET, 8'h00, RST_MAX_ROW + 8'd1, RST_MAX_COL);
        send_cmd(CMD_SET, 8'h00, RST_MAX_ROW, RST_MAX_COL);
        send_cmd(CMD_PUT, CHR_LF, 8'd0, 8'd1);
        send_cmd(CMD_PUT, 8'h7E, 8'd0, 8'd1);
        send_cmd(CMD_CLS, 8'h00, 8'd0, 8'd1);
        send_cmd(CMD_UNUSED, 8'h41, 8'd3, 8'd3);
        send_cmd(CMD_SET, 8'h00, 8'd1, 8'd1);
        send_cmd(CMD_PUT, CHR_BS, 8'd0, 8'd1);
        send_cmd(CMD_SET, 8'h00, 8'd8, 8'd200);
        send_cmd(CMD_PUT, 8'h20, 8'd0, 8'd1);
        send_cmd(CMD_PUT, 8'h41, 8'd0, 8'd1);
        run_random(50);

        program_display(10'd1, 10'd2, 5'd1, 4'd1, 8'd1, 8'd1);
        run_random(RANDOM_PER_PHASE);
        program_display(10'd1023, 10'd1022, 5'd31, 4'd15, 8'd255, 8'd255);
        run_random(RANDOM_PER_PHASE);
        program_display(10'd60, 10'd128, 5'd8, 4'd6, 8'd10, 8'd4);
        run_random(RANDOM_PER_PHASE);
        repeat (3)
        begin
            program_random_display();
            run_random(RANDOM_PER_PHASE);
        end

        drain();
        if (mismatches == 0 && backlog == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
